// ===== design/tsneg_pkg.sv =====
// Shared types, constants and the lit_level helper function of the touch scan note event generator.
package tsneg_pkg;

  localparam int DEF_MODULES         = 4;
  localparam int DEF_SENSORS_PER_MOD = 8;

  localparam int REQ_W   = 2;
  localparam int MOD_W   = 2;
  localparam int BITS_W  = 8;
  localparam int ENTRY_W = 5;
  localparam int NOTE_W  = 7;
  localparam int KIND_W  = 2;
  localparam int OIDX_W  = 5;
  localparam int DRV_W   = 8;
  localparam int OCNT_W  = 6;
  localparam int PCT_W   = 7;
  localparam int HOLD_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_INTENSITY = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HOLD      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ANODE     = 2'd2;

  localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] EV_STATUS   = 2'd2;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_TICK,
    CMD_LOAD,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [MOD_W-1:0]    module_index;
    logic [BITS_W-1:0]   sensor_bits;
    logic [ENTRY_W-1:0]  entry_index;
    logic [NOTE_W-1:0]   entry_note;
  } cmd_t;

  typedef struct packed {
    logic [DRV_W-1:0]  lit_level;
    logic [HOLD_W-1:0] hold_ms;
    logic              inv_drive;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [OIDX_W-1:0] sensor_index;
    logic [NOTE_W-1:0] note;
    logic [DRV_W-1:0]  red_drive;
    logic [DRV_W-1:0]  green_drive;
    logic [OCNT_W-1:0] active_count;
    logic              last;
  } res_t;

  // pct*255/100 with pct clamped to 100; the /100 is a reciprocal multiply (exact up to 25500)
  function automatic logic [DRV_W-1:0] lit_level(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [14:0]      x;
    logic [27:0]      y;
    p = (pct > 7'd100) ? 7'd100 : pct;
    x = {p, 8'd0} - 15'(p);
    y = 28'(x) * 28'd5243;
    return y[26:19];
  endfunction

endpackage

// ===== design/tsneg_front.sv =====
// Front end: accepts input transfers, classifies them and queues commands for the back end.
module tsneg_front
  import tsneg_pkg::*;
#(
  parameter int MODULES         = DEF_MODULES,
  parameter int SENSORS_PER_MOD = DEF_SENSORS_PER_MOD
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [MOD_W-1:0]    module_index,
  input  logic [BITS_W-1:0]   sensor_bits,
  input  logic [ENTRY_W-1:0]  entry_index,
  input  logic [NOTE_W-1:0]   entry_note,
  output logic                q_valid,
  output cmd_t                q_cmd,
  input  logic                q_pop
);

  localparam int TOTAL = MODULES * SENSORS_PER_MOD;
  localparam logic [BITS_W-1:0] BIT_MASK = BITS_W'((1 << SENSORS_PER_MOD) - 1);

  cmd_t       cmd;
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    cmd.module_index = module_index;
    cmd.sensor_bits  = sensor_bits & BIT_MASK;
    cmd.entry_index  = entry_index;
    cmd.entry_note   = entry_note;
    case (req_type)
      REQ_REPORT: cmd.kind = (32'(module_index) < MODULES) ? CMD_REPORT : CMD_NONE;
      REQ_TICK:   cmd.kind = CMD_TICK;
      REQ_LOAD:   cmd.kind = (32'(entry_index) < TOTAL) ? CMD_LOAD : CMD_NONE;
      default:    cmd.kind = CMD_NONE;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== design/tsneg_back.sv =====
// Back end: sensor scan sequencer, note table, LED state and result register.
module tsneg_back
  import tsneg_pkg::*;
#(
  parameter int MODULES         = DEF_MODULES,
  parameter int SENSORS_PER_MOD = DEF_SENSORS_PER_MOD
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int TOTAL = MODULES * SENSORS_PER_MOD;
  localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W = $clog2(TOTAL + 1);
  localparam int S_W   = (SENSORS_PER_MOD > 1) ? $clog2(SENSORS_PER_MOD) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_STATUS} state_t;
  typedef enum logic [1:0] {COL_RED, COL_YELLOW, COL_GREEN} color_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [S_W-1:0]    s_r, s_nxt;
  logic [TOTAL-1:0]  on_r, on_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HOLD_W-1:0] idle_r, idle_nxt;
  color_t            color_r, color_nxt;

  logic              p_valid_r, p_valid_nxt;
  logic [KIND_W-1:0] p_kind_r, p_kind_nxt;
  logic [OIDX_W-1:0] p_idx_r, p_idx_nxt;
  logic [DRV_W-1:0]  p_red_r, p_red_nxt;
  logic [DRV_W-1:0]  p_green_r, p_green_nxt;
  logic [OCNT_W-1:0] p_cnt_r, p_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic [NOTE_W-1:0] mem [TOTAL];
  logic [NOTE_W-1:0] rd_note_r;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;

  logic              out_load, p_free;
  logic [31:0]       idx32, ent32, cnt32;
  logic [IDX_W-1:0]  idx;
  logic              touched, changed;
  logic [CNT_W-1:0]  cnt_step;
  color_t            col_new;
  logic [HOLD_W-1:0] idle_new;

  function automatic logic [DRV_W-1:0] drive(input logic lit, input cfg_t c);
    logic [DRV_W-1:0] v;
    v = lit ? c.lit_level : '0;
    return c.inv_drive ? ~v : v;
  endfunction

  function automatic logic red_lit(input color_t c);
    return (c == COL_RED) || (c == COL_YELLOW);
  endfunction

  function automatic logic green_lit(input color_t c);
    return (c == COL_YELLOW) || (c == COL_GREEN);
  endfunction

  assign out_load = p_valid_r && (!out_valid_r || out_ready);
  assign p_free   = !p_valid_r || out_load;

  assign idx32   = 32'(cmd_r.module_index) * SENSORS_PER_MOD + 32'(s_r);
  assign idx     = idx32[IDX_W-1:0];
  assign ent32   = 32'(cmd_r.entry_index);
  assign touched = cmd_r.sensor_bits[s_r];
  assign changed = touched != on_r[idx];
  assign cnt_step = touched ? cnt_r + CNT_W'(1) : cnt_r - CNT_W'(1);

  always_comb begin
    col_new  = color_r;
    idle_new = idle_r;
    if (cnt_r != '0) begin
      col_new  = (cnt_r == CNT_W'(1)) ? COL_YELLOW : COL_GREEN;
      idle_new = '0;
    end else if (idle_r >= cfg.hold_ms) begin
      col_new  = COL_RED;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    s_nxt       = s_r;
    on_nxt      = on_r;
    cnt_nxt     = cnt_r;
    idle_nxt    = idle_r;
    color_nxt   = color_r;
    p_valid_nxt = out_load ? 1'b0 : p_valid_r;
    p_kind_nxt  = p_kind_r;
    p_idx_nxt   = p_idx_r;
    p_red_nxt   = p_red_r;
    p_green_nxt = p_green_r;
    p_cnt_nxt   = p_cnt_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = idx;
    wr_addr     = ent32[IDX_W-1:0];
    cnt32       = 32'(cnt_step);

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          s_nxt   = '0;
          case (q_cmd.kind)
            CMD_REPORT: state_nxt = ST_SCAN;
            CMD_TICK: begin
              if (idle_r != '1) begin
                idle_nxt = idle_r + HOLD_W'(1);
              end
              state_nxt = ST_STATUS;
            end
            default: state_nxt = ST_STATUS;
          endcase
        end
      end
      ST_SCAN: begin
        if (!changed || p_free) begin
          if (changed) begin
            on_nxt[idx] = touched;
            cnt_nxt     = cnt_step;
            rd_en       = 1'b1;
            p_valid_nxt = 1'b1;
            p_kind_nxt  = touched ? EV_NOTE_ON : EV_NOTE_OFF;
            p_idx_nxt   = idx32[OIDX_W-1:0];
            p_red_nxt   = drive(red_lit(color_r), cfg);
            p_green_nxt = drive(green_lit(color_r), cfg);
            p_cnt_nxt   = cnt32[OCNT_W-1:0];
          end
          if (s_r == S_W'(SENSORS_PER_MOD - 1)) begin
            state_nxt = ST_STATUS;
          end else begin
            s_nxt = s_r + S_W'(1);
          end
        end
      end
      ST_STATUS: begin
        wr_en = (cmd_r.kind == CMD_LOAD);
        if (p_free) begin
          cnt32       = 32'(cnt_r);
          color_nxt   = col_new;
          idle_nxt    = idle_new;
          p_valid_nxt = 1'b1;
          p_kind_nxt  = EV_STATUS;
          p_idx_nxt   = '0;
          p_red_nxt   = drive(red_lit(col_new), cfg);
          p_green_nxt = drive(green_lit(col_new), cfg);
          p_cnt_nxt   = cnt32[OCNT_W-1:0];
          cmd_nxt.kind = CMD_NONE;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_nxt       = out_r;
    if (out_load) begin
      out_nxt.event_kind   = p_kind_r;
      out_nxt.sensor_index = p_idx_r;
      out_nxt.note         = (p_kind_r == EV_STATUS) ? '0 : rd_note_r;
      out_nxt.red_drive    = p_red_r;
      out_nxt.green_drive  = p_green_r;
      out_nxt.active_count = p_cnt_r;
      out_nxt.last         = (p_kind_r == EV_STATUS);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_r.entry_note;
    end
    if (rd_en) begin
      rd_note_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r.kind  <= CMD_NONE;
      s_r         <= '0;
      on_r        <= '0;
      cnt_r       <= '0;
      idle_r      <= '0;
      color_r     <= COL_RED;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r.kind  <= cmd_nxt.kind;
      s_r         <= s_nxt;
      on_r        <= on_nxt;
      cnt_r       <= cnt_nxt;
      idle_r      <= idle_nxt;
      color_r     <= color_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r.module_index <= cmd_nxt.module_index;
    cmd_r.sensor_bits  <= cmd_nxt.sensor_bits;
    cmd_r.entry_index  <= cmd_nxt.entry_index;
    cmd_r.entry_note   <= cmd_nxt.entry_note;
    p_kind_r           <= p_kind_nxt;
    p_idx_r            <= p_idx_nxt;
    p_red_r            <= p_red_nxt;
    p_green_r          <= p_green_nxt;
    p_cnt_r            <= p_cnt_nxt;
    out_r              <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== design/touch_scan_note_event_generator_unit.sv =====
// Top level of the touch scan note event generator: ports, configuration registers, assertions.
//
//   channel  direction  handshake          payload
//   in_      slave      in_tvalid/tready   tuser req_type; tdata report/load fields
//   out_     master     out_tvalid/tready  tuser event_kind; tlast; tdata event fields
//   cfg_     write      cfg_we             cfg_index, cfg_wdata
//
// Back end: it fetches a report command, scans the sensors of the module one by one, then
// gives the status result; tick, load and ignored items go from the fetch to the status result.
// A changed sensor waits in the scan while the result register and its pending stage are full.
// The two-entry command queue keeps the input side open while the back end works.
// Reset is synchronous; sensor state, count, idle time and LED colour clear at once,
// the note table is not cleared and has no clearing pass.
module touch_scan_note_event_generator_unit
  import tsneg_pkg::*;
#(
  parameter int MODULES         = DEF_MODULES,
  parameter int SENSORS_PER_MOD = DEF_SENSORS_PER_MOD
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // module_index, sensor_bits, entry_index, entry_note, pad
  input  logic [REQ_W-1:0]  in_tuser,   // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  // sensor_index, note, red_drive, green_drive, active_count, pad
  output logic [39:0]       out_tdata,
  output logic [KIND_W-1:0] out_tuser,  // event_kind
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [PCT_W-1:0]  intensity_r;
  logic [HOLD_W-1:0] hold_r;
  logic              anode_r;
  logic [DRV_W-1:0]  lit_r;
  cfg_t              cfg;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= PCT_W'(100);
      hold_r      <= HOLD_W'(1000);
      anode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTENSITY: intensity_r <= cfg_wdata[PCT_W-1:0];
        CFG_HOLD:      hold_r      <= cfg_wdata[HOLD_W-1:0];
        CFG_ANODE:     anode_r     <= cfg_wdata[0];
        default:       ;
      endcase
    end
    lit_r <= lit_level(intensity_r);
  end

  assign cfg.lit_level = lit_r;
  assign cfg.hold_ms   = hold_r;
  assign cfg.inv_drive = anode_r;

  tsneg_front #(
    .MODULES         (MODULES),
    .SENSORS_PER_MOD (SENSORS_PER_MOD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tuser),
    .module_index (in_tdata[1:0]),
    .sensor_bits  (in_tdata[9:2]),
    .entry_index  (in_tdata[14:10]),
    .entry_note   (in_tdata[21:15]),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  tsneg_back #(
    .MODULES         (MODULES),
    .SENSORS_PER_MOD (SENSORS_PER_MOD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'd0, res.active_count, res.green_drive, res.red_drive,
                      res.note, res.sensor_index};
  assign out_tuser = res.event_kind;
  assign out_tlast = res.last;

  a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == EV_STATUS)))
    else $error("tlast does not match status kind");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EV_STATUS) |-> (out_tdata[11:0] == 12'd0))
    else $error("status transfer carries sensor index or note");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[33:28]) <= MODULES * SENSORS_PER_MOD))
    else $error("active count beyond sensor total");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_tready)
    else $error("input not ready after reset");

endmodule

// ===== verif/touch_scan_note_event_generator_unit_tb.sv =====
// Self-checking testbench for the touch scan note event generator unit.
module touch_scan_note_event_generator_unit_tb;
  import tsneg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = DEF_SENSORS_PER_MOD + 6;
  localparam int NSENS = DEF_MODULES * DEF_SENSORS_PER_MOD;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    LED_RED,
    LED_YELLOW,
    LED_GREEN
  } led_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic [REQ_W-1:0]  in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // sender / receiver behaviour, idle and stall chances in percent
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_until = 0;
  int unsigned cycles = 0;
  int          mismatches = 0;

  // predictor state
  logic [PCT_W-1:0]  lit_pct = 7'd100;
  logic [HOLD_W-1:0] hold_limit = 16'd1000;
  bit                anode_mode = 1'b0;
  bit [NSENS-1:0]    sensor_held = '0;
  bit [NSENS-1:0]    note_loaded = '0;
  logic [NOTE_W-1:0] note_map [NSENS];
  logic [OCNT_W-1:0] held_count = '0;
  logic [HOLD_W-1:0] idle_count = '0;
  led_t              led = LED_RED;
  res_t              due_results [$];

  touch_scan_note_event_generator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles < rx_hold_until) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic [DRV_W-1:0] drive_level(input bit lit);
    int pct;
    int v;
    pct = lit ? int'(lit_pct) : 0;
    if (pct > 100) pct = 100;
    v = pct * 255 / 100;
    if (anode_mode) v = 255 - v;
    return v[DRV_W-1:0];
  endfunction

  task automatic push_result(input logic [KIND_W-1:0] kind, input int idx,
                             input logic [NOTE_W-1:0] note, input bit is_last);
    res_t r;
    r.event_kind   = kind;
    r.sensor_index = idx[OIDX_W-1:0];
    r.note         = note;
    r.red_drive    = drive_level(led == LED_RED || led == LED_YELLOW);
    r.green_drive  = drive_level(led == LED_YELLOW || led == LED_GREEN);
    r.active_count = held_count;
    r.last         = is_last;
    due_results.push_back(r);
  endtask

  task automatic predict_events(input logic [REQ_W-1:0] req, input logic [23:0] p);
    int idx;
    bit touched;
    case (req)
      REQ_REPORT: begin
        for (int s = 0; s < DEF_SENSORS_PER_MOD; s++) begin
          idx = int'(p[1:0]) * DEF_SENSORS_PER_MOD + s;
          touched = p[2 + s];
          if (touched && !sensor_held[idx]) begin
            sensor_held[idx] = 1'b1;
            held_count++;
            push_result(EV_NOTE_ON, idx, note_map[idx], 1'b0);
          end else if (!touched && sensor_held[idx]) begin
            sensor_held[idx] = 1'b0;
            held_count--;
            push_result(EV_NOTE_OFF, idx, note_map[idx], 1'b0);
          end
        end
      end
      REQ_TICK: begin
        if (idle_count != 16'hFFFF) idle_count++;
      end
      REQ_LOAD: begin
        note_map[p[14:10]] = p[21:15];
        note_loaded[p[14:10]] = 1'b1;
      end
      default: ;
    endcase
    if (held_count != 0) begin
      led = (held_count == 1) ? LED_YELLOW : LED_GREEN;
      idle_count = '0;
    end else if (idle_count >= hold_limit) begin
      led = LED_RED;
    end
    push_result(EV_STATUS, 0, '0, 1'b1);
  endtask

  task automatic cmp(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual kind %0d data %h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        cmp("event_kind", want.event_kind, out_tuser);
        cmp("sensor_index", want.sensor_index, out_tdata[4:0]);
        cmp("note", want.note, out_tdata[11:5]);
        cmp("red_drive", want.red_drive, out_tdata[19:12]);
        cmp("green_drive", want.green_drive, out_tdata[27:20]);
        cmp("active_count", want.active_count, out_tdata[33:28]);
        cmp("last", want.last, out_tlast);
      end
    end
  end

  function automatic logic [23:0] pack_fields(input logic [MOD_W-1:0] m,
                                              input logic [BITS_W-1:0] bits,
                                              input logic [ENTRY_W-1:0] eidx,
                                              input logic [NOTE_W-1:0] enote);
    return {2'b00, enote, eidx, bits, m};
  endfunction

  // sensors with no note loaded keep their state
  function automatic logic [BITS_W-1:0] safe_bits(input logic [MOD_W-1:0] m,
                                                  input logic [BITS_W-1:0] raw);
    int idx;
    for (int s = 0; s < DEF_SENSORS_PER_MOD; s++) begin
      idx = int'(m) * DEF_SENSORS_PER_MOD + s;
      if (!note_loaded[idx]) raw[s] = sensor_held[idx];
    end
    return raw;
  endfunction

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [23:0] payload);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_events(req, payload);
  endtask

  task automatic send_random();
    int pick;
    logic [REQ_W-1:0] req;
    logic [MOD_W-1:0] m;
    logic [BITS_W-1:0] raw;
    pick = $urandom_range(0, 99);
    m = MOD_W'($urandom);
    raw = BITS_W'($urandom);
    if (pick < 45) req = REQ_REPORT;
    else if (pick < 80) req = REQ_TICK;
    else if (pick < 95) req = REQ_LOAD;
    else req = REQ_UNUSED;
    if (req == REQ_REPORT) raw = safe_bits(m, raw);
    send_item(req, pack_fields(m, raw, ENTRY_W'($urandom), NOTE_W'($urandom)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [PCT_W-1:0] pct, input logic [HOLD_W-1:0] hold,
                              input bit anode);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTENSITY;
    cfg_wdata <= CFG_W'(pct);
    @(posedge clk);
    cfg_index <= CFG_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= CFG_ANODE;
    cfg_wdata <= CFG_W'(anode);
    @(posedge clk);
    cfg_we <= 1'b0;
    lit_pct    = pct;
    hold_limit = hold;
    anode_mode = anode;
  endtask

  task automatic run_random(input int n, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) wait_drained();
      send_random();
    end
    wait_drained();
  endtask

  // reset values, unused request type, table extremes, full and partial reports
  task automatic test_directed();
    send_item(REQ_TICK, pack_fields(2'd3, 8'hFF, 5'd31, 7'd127));
    send_item(REQ_UNUSED, pack_fields(2'd0, 8'h00, 5'd0, 7'd0));
    for (int e = 0; e < DEF_SENSORS_PER_MOD; e++) begin
      send_item(REQ_LOAD, pack_fields(2'd0, 8'h00, ENTRY_W'(e),
                                      (e == 0) ? 7'd0 : (e == 1) ? 7'd127 : NOTE_W'(40 + e)));
    end
    send_item(REQ_LOAD, pack_fields(2'd2, 8'hAA, 5'd31, 7'd127));
    send_item(REQ_LOAD, pack_fields(2'd1, 8'h55, 5'd24, 7'd1));
    send_item(REQ_REPORT, pack_fields(2'd0, 8'hFF, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h7F, 5'd31, 7'd127));
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h01, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd3, 8'h81, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd3, 8'h00, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h00, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd1, 8'h00, 5'd0, 7'd0));
    send_item(REQ_TICK, pack_fields(2'd0, 8'h00, 5'd0, 7'd0));
    wait_drained();
  endtask

  task automatic test_no_idling();
    apply_config(7'd100, 16'd0, 1'b0);
    run_random(20, 0, 0);
  endtask

  task automatic test_sender_idle();
    apply_config(7'd0, 16'd3, 1'b1);
    run_random(20, 78, 0);
  endtask

  task automatic test_receiver_stall();
    apply_config(7'd127, 16'd2, 1'b0);
    run_random(20, 0, 78);
  endtask

  task automatic test_both_idle();
    apply_config(7'd50, 16'd5, 1'b1);
    run_random(20, 7, 7);
  endtask

  // long receiver hold-off while reports keep coming
  task automatic test_backpressure();
    logic [MOD_W-1:0] m;
    apply_config(7'd73, 16'd1, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_until <= cycles + 400;
    for (int i = 0; i < 16; i++) begin
      m = MOD_W'($urandom);
      send_item(REQ_REPORT, pack_fields(m, safe_bits(m, 8'($urandom)),
                                        ENTRY_W'($urandom), NOTE_W'($urandom)));
    end
    wait_drained();
  endtask

  // longest hold time: the colour is kept while idle ticks run
  task automatic test_hold_limit();
    apply_config(7'd1, 16'hFFFF, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int m = 0; m < DEF_MODULES; m++) begin
      send_item(REQ_REPORT, pack_fields(MOD_W'(m), 8'h00, 5'd0, 7'd0));
    end
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h03, 5'd0, 7'd0));
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h00, 5'd0, 7'd0));
    for (int i = 0; i < 5; i++) begin
      send_item(REQ_TICK, pack_fields(MOD_W'($urandom), 8'($urandom),
                                      ENTRY_W'($urandom), NOTE_W'($urandom)));
    end
    send_item(REQ_REPORT, pack_fields(2'd0, 8'h01, 5'd0, 7'd0));
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_hold_limit();
    apply_config(7'd100, 16'd1000, 1'b0);
    run_random(4, 7, 7);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tsneg_pkg.sv
design/tsneg_front.sv
design/tsneg_back.sv
design/touch_scan_note_event_generator_unit.sv
verif/touch_scan_note_event_generator_unit_tb.sv
